// ----- design/sust_pkg.sv -----
`default_nettype none

package sust_pkg;

	localparam int DefCapacity = 16;
	localparam int ValW        = 32;

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_READ   = 2'd1,
		ACT_REMOVE = 2'd2
	} action_t;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_DUP   = 3'd1,
		ST_EMPTY = 3'd2,
		ST_RANGE = 3'd3,
		ST_FULL  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE  = 2'd0,
		FSM_CMP   = 2'd1,
		FSM_APPLY = 2'd2
	} fsm_t;

	// Broadcast control from the sequencer to every cell
	typedef struct packed {
		logic                   cmp_en;
		logic                   ins_en;
		logic                   rem_en;
		logic signed [ValW-1:0] value;
	} cell_ctrl_t;

endpackage

`default_nettype wire

// ----- design/sorted_unique_set_table.sv -----
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall  action, value, position
// out      output     out_valid / out_stall read_value, status, entry_count
//
// Each request passes through three steps: accept, compare in every cell, apply.
// The apply step waits while a previous result is held by out_stall.
// Reset clears the entry count and the output valid; entries are undefined
// until written and are only read below the count.
// in_stall is high from acceptance until the apply step completes.
`default_nettype none

module sorted_unique_set_table #(
	parameter int CAPACITY = sust_pkg::DefCapacity
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               in_valid,
	output logic                              in_stall,
	input  wire  [1:0]                        action,
	input  wire  signed [sust_pkg::ValW-1:0]  value,
	input  wire  [3:0]                        position,
	output logic                              out_valid,
	input  wire                               out_stall,
	output logic signed [sust_pkg::ValW-1:0]  read_value,
	output logic [2:0]                        status,
	output logic [4:0]                        entry_count
);
	import sust_pkg::*;

	localparam int CntW = $clog2(CAPACITY + 1);
	localparam int IdxW = $clog2(CAPACITY);
	localparam int PosW = IdxW + 4;

	fsm_t                   state_q, state_d;
	logic [1:0]             action_q;
	logic signed [ValW-1:0] value_q;
	logic [3:0]             pos_q;
	logic [CntW-1:0]        count_q, count_d;
	logic                   out_valid_q;
	logic signed [ValW-1:0] read_value_q;
	status_t                status_q;
	logic [4:0]             entry_count_q;

	cell_ctrl_t             ctrl;
	logic signed [ValW-1:0] entries [CAPACITY];
	logic [CAPACITY-1:0]    lt_v;
	logic [CAPACITY-1:0]    eq_v;
	logic [CAPACITY-1:0]    occ_v;
	logic [CAPACITY-1:0]    rem_v;

	logic                   apply_go;
	logic [PosW-1:0]        pos_ext;
	logic [PosW-1:0]        cnt_ext;
	logic [IdxW-1:0]        rd_idx;
	logic [CntW+4:0]        cnt_wide;
	logic signed [ValW-1:0] rv_d;
	status_t                status_d;

	assign pos_ext  = {{IdxW{1'b0}}, pos_q};
	assign cnt_ext  = {{(PosW - CntW){1'b0}}, count_q};
	assign rd_idx   = pos_ext[IdxW-1:0];
	assign cnt_wide = {5'b0, count_d};
	assign apply_go = (state_q == FSM_APPLY) && (!out_valid_q || !out_stall);

	// Build the cell chain
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		assign occ_v[g] = (CntW'(g) < count_q);
		assign rem_v[g] = (PosW'(g) >= pos_ext);

		if (g == 0) begin : g_first
			sust_cell u_cell (
				.clk        (clk),
				.ctrl       (ctrl),
				.occupied   (occ_v[g]),
				.rem_take   (rem_v[g]),
				.prev_lt    (1'b1),
				.prev_entry (value_q),
				.next_entry (entries[(g + 1) % CAPACITY]),
				.entry      (entries[g]),
				.lt         (lt_v[g]),
				.eq         (eq_v[g])
			);
		end else if (g == CAPACITY - 1) begin : g_last
			sust_cell u_cell (
				.clk        (clk),
				.ctrl       (ctrl),
				.occupied   (occ_v[g]),
				.rem_take   (rem_v[g]),
				.prev_lt    (lt_v[g-1]),
				.prev_entry (entries[g-1]),
				.next_entry (entries[g]),
				.entry      (entries[g]),
				.lt         (lt_v[g]),
				.eq         (eq_v[g])
			);
		end else begin : g_mid
			sust_cell u_cell (
				.clk        (clk),
				.ctrl       (ctrl),
				.occupied   (occ_v[g]),
				.rem_take   (rem_v[g]),
				.prev_lt    (lt_v[g-1]),
				.prev_entry (entries[g-1]),
				.next_entry (entries[g+1]),
				.entry      (entries[g]),
				.lt         (lt_v[g]),
				.eq         (eq_v[g])
			);
		end
	end

	// Hold the accepted request
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			action_q <= action;
			value_q  <= value;
			pos_q    <= position;
		end
	end

	// Advance the sequencer and the count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	// Decide next state, cell controls and the result
	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		in_stall     = 1'b1;
		ctrl.cmp_en  = 1'b0;
		ctrl.ins_en  = 1'b0;
		ctrl.rem_en  = 1'b0;
		ctrl.value   = value_q;
		rv_d         = '0;
		status_d     = ST_OK;
		case (state_q)
			FSM_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = FSM_CMP;
				end
			end
			FSM_CMP: begin
				ctrl.cmp_en = 1'b1;
				state_d     = FSM_APPLY;
			end
			FSM_APPLY: begin
				case (action_q)
					ACT_INSERT: begin
						if (|eq_v) begin
							status_d = ST_DUP;
						end else if (count_q >= CntW'(CAPACITY)) begin
							status_d = ST_FULL;
						end else begin
							ctrl.ins_en = apply_go;
						end
					end
					ACT_READ, ACT_REMOVE: begin
						if (count_q == '0) begin
							status_d = ST_EMPTY;
						end else if (pos_ext >= cnt_ext) begin
							status_d = ST_RANGE;
						end else if (action_q == ACT_READ) begin
							rv_d = entries[rd_idx];
						end else begin
							ctrl.rem_en = apply_go;
						end
					end
					default: begin
						status_d = ST_OK;
					end
				endcase
				if (apply_go) begin
					state_d = FSM_IDLE;
					if (ctrl.ins_en) begin
						count_d = count_q + 1'b1;
					end else if (ctrl.rem_en) begin
						count_d = count_q - 1'b1;
					end
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	// Load the output register, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (apply_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (apply_go) begin
			read_value_q  <= rv_d;
			status_q      <= status_d;
			entry_count_q <= cnt_wide[4:0];
		end
	end

	assign out_valid   = out_valid_q;
	assign read_value  = read_value_q;
	assign status      = status_q;
	assign entry_count = entry_count_q;

`ifndef SYNTHESIS
	a_accept_to_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == FSM_CMP)
		else $error("accepted request did not enter compare");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(CAPACITY))
		else $error("entry count exceeds capacity");

	a_count_on_apply: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count_q) |-> $past(apply_go))
		else $error("entry count changed outside apply");

	a_result_on_apply: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == FSM_APPLY)
		else $error("result appeared without apply");
`endif

endmodule

`default_nettype wire

// ----- design/sust_cell.sv -----
`default_nettype none

module sust_cell (
	input  wire                                clk,
	input  wire  sust_pkg::cell_ctrl_t         ctrl,
	input  wire                                occupied,
	input  wire                                rem_take,
	input  wire                                prev_lt,
	input  wire  signed [sust_pkg::ValW-1:0]   prev_entry,
	input  wire  signed [sust_pkg::ValW-1:0]   next_entry,
	output logic signed [sust_pkg::ValW-1:0]   entry,
	output logic                               lt,
	output logic                               eq
);
	import sust_pkg::*;

	logic signed [ValW-1:0] entry_q;
	logic                   lt_q;
	logic                   eq_q;

	// Compare the stored entry against the broadcast value
	always_ff @(posedge clk) begin
		if (ctrl.cmp_en) begin
			lt_q <= occupied && (entry_q < ctrl.value);
			eq_q <= occupied && (entry_q == ctrl.value);
		end
	end

	// Shift up on insert at or after the slot, shift down on remove
	always_ff @(posedge clk) begin
		if (ctrl.ins_en && !lt_q) begin
			entry_q <= prev_lt ? ctrl.value : prev_entry;
		end else if (ctrl.rem_en && rem_take) begin
			entry_q <= next_entry;
		end
	end

	assign entry = entry_q;
	assign lt    = lt_q;
	assign eq    = eq_q;

endmodule

`default_nettype wire

// ----- bench/set_table_checker.sv -----
`timescale 1ns / 100ps

module set_table_checker #(
	parameter int CAPACITY = sust_pkg::DefCapacity
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               in_valid,
	input  wire                               in_stall,
	input  wire  [1:0]                        action,
	input  wire  signed [sust_pkg::ValW-1:0]  value,
	input  wire  [3:0]                        position,
	input  wire                               out_valid,
	input  wire                               out_stall,
	input  wire  signed [sust_pkg::ValW-1:0]  read_value,
	input  wire  [2:0]                        status,
	input  wire  [4:0]                        entry_count,
	output int                                fail_count,
	output int                                replies_owed
);
	import sust_pkg::*;

	typedef struct packed {
		logic signed [ValW-1:0] rd;
		status_t                st;
		logic [4:0]             cnt;
	} set_reply_t;

	// Mirror of the sorted contents, valid below mirror_count
	logic signed [ValW-1:0] mirror_vals [CAPACITY];
	int                     mirror_count = 0;
	set_reply_t             replies_due [$];
	int                     errs = 0;

	task automatic report_mismatch(input string msg);
		$display("[%0t] set table check: %s", $time, msg);
		errs++;
	endtask

	// Apply one request to the mirror and return the reply it should produce
	function automatic set_reply_t apply_to_set(input logic [1:0] act,
			input logic signed [ValW-1:0] val, input logic [3:0] pos);
		set_reply_t r;
		int         slot;
		r.rd = '0;
		r.st = ST_OK;
		if (act == ACT_INSERT) begin
			slot = 0;
			while (slot < mirror_count && mirror_vals[slot] < val)
				slot++;
			// a duplicate wins over a full set
			if (slot < mirror_count && mirror_vals[slot] == val) begin
				r.st = ST_DUP;
			end else if (mirror_count >= CAPACITY) begin
				r.st = ST_FULL;
			end else begin
				for (int k = mirror_count; k > slot; k--)
					mirror_vals[k] = mirror_vals[k-1];
				mirror_vals[slot] = val;
				mirror_count++;
			end
		end else if (act == ACT_READ || act == ACT_REMOVE) begin
			if (mirror_count == 0) begin
				r.st = ST_EMPTY;
			end else if (int'(pos) >= mirror_count) begin
				r.st = ST_RANGE;
			end else if (act == ACT_READ) begin
				r.rd = mirror_vals[pos];
			end else begin
				// close the gap left by the removed entry
				for (int k = int'(pos); k + 1 < mirror_count; k++)
					mirror_vals[k] = mirror_vals[k+1];
				mirror_count--;
			end
		end
		r.cnt = 5'(mirror_count);
		return r;
	endfunction

	// Predict on each accepted request, compare on each accepted reply
	always @(posedge clk) begin : watch
		set_reply_t want;
		if (arst_n) begin
			if (in_valid && !in_stall)
				replies_due.push_back(apply_to_set(action, value, position));
			if (out_valid && !out_stall) begin
				if (replies_due.size() == 0) begin
					report_mismatch($sformatf("unexpected reply rd=%0d st=%0d cnt=%0d",
						read_value, status, entry_count));
				end else begin
					want = replies_due.pop_front();
					if (read_value !== want.rd)
						report_mismatch($sformatf("read_value %0d, want %0d",
							read_value, want.rd));
					if (status !== want.st)
						report_mismatch($sformatf("status %0d, want %0d",
							status, want.st));
					if (entry_count !== want.cnt)
						report_mismatch($sformatf("entry_count %0d, want %0d",
							entry_count, want.cnt));
				end
			end
		end
		fail_count   <= errs;
		replies_owed <= replies_due.size();
	end

endmodule

// ----- bench/tb_sorted_unique_set_table.sv -----
`timescale 1ns / 100ps

module tb_sorted_unique_set_table;
	import sust_pkg::*;

	localparam int CAPACITY    = DefCapacity;
	localparam int RandomItems = 725;
	localparam int CycleLimit  = 200000;
	localparam int DrainCycles = 12;
	localparam int HoldStart   = 1200;
	localparam int HoldLen     = 400;
	localparam int RxQuietFrom = 2200;
	localparam int RxQuietTo   = 2800;
	localparam int TideLen     = 60;

	localparam logic [1:0]             ActNop = 2'd3;
	localparam logic signed [ValW-1:0] ValMin = 32'sh8000_0000;
	localparam logic signed [ValW-1:0] ValMax = 32'sh7fff_ffff;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   in_valid  = 1'b0;
	logic                   in_stall;
	logic [1:0]             action    = ACT_INSERT;
	logic signed [ValW-1:0] value     = '0;
	logic [3:0]             position  = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic signed [ValW-1:0] read_value;
	logic [2:0]             status;
	logic [4:0]             entry_count;
	int                     fail_count;
	int                     owed;
	int                     cycles    = 0;
	int                     rx_cycle  = 0;

	sorted_unique_set_table #(
		.CAPACITY(CAPACITY)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.value       (value),
		.position    (position),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.read_value  (read_value),
		.status      (status),
		.entry_count (entry_count)
	);

	set_table_checker #(
		.CAPACITY(CAPACITY)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.value        (value),
		.position     (position),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.read_value   (read_value),
		.status       (status),
		.entry_count  (entry_count),
		.fail_count   (fail_count),
		.replies_owed (owed)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("[sorted_unique_set_table] ERROR");
			$finish;
		end
	end

	// Receiver: random stalls, one long hold-off, one quiet stretch
	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 1;
		if (rx_cycle >= HoldStart && rx_cycle < HoldStart + HoldLen)
			out_stall <= 1'b1;
		else if (rx_cycle >= RxQuietFrom && rx_cycle < RxQuietTo)
			out_stall <= 1'b0;
		else
			out_stall <= ($urandom_range(99) < 19);
	end

	// Offer one request and hold it until accepted
	task automatic offer(input logic [1:0] a, input logic signed [ValW-1:0] v,
			input logic [3:0] p, input bit may_idle);
		while (may_idle && $urandom_range(99) < 19) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action   <= a;
		value    <= v;
		position <= p;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Mostly a small pool to hit duplicates, some extremes, rest anywhere
	function automatic logic signed [ValW-1:0] pick_value();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 50)
			return int'($urandom_range(31)) - 16;
		if (r < 65) begin
			case ($urandom_range(3))
				0: return ValMin;
				1: return ValMax;
				2: return -1;
				default: return 0;
			endcase
		end
		return $urandom();
	endfunction

	// Alternate fill and drain tides so the count sweeps empty to full
	function automatic logic [1:0] pick_action(input int idx);
		int unsigned r;
		bit          filling;
		r       = $urandom_range(99);
		filling = ((idx / TideLen) % 2 == 0);
		if (r >= 95)
			return ActNop;
		if (filling)
			return (r < 60) ? ACT_INSERT : (r < 85) ? ACT_READ : ACT_REMOVE;
		return (r < 20) ? ACT_INSERT : (r < 45) ? ACT_READ : ACT_REMOVE;
	endfunction

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty set, unused code, extremes, duplicate, range errors
		offer(ACT_READ,   0,      4'd0,  1'b1);
		offer(ACT_REMOVE, 0,      4'd15, 1'b1);
		offer(ActNop,     -1,     4'd15, 1'b1);
		offer(ACT_INSERT, 0,      4'd0,  1'b1);
		offer(ACT_INSERT, ValMin, 4'd0,  1'b1);
		offer(ACT_INSERT, ValMax, 4'd0,  1'b1);
		offer(ACT_INSERT, 0,      4'd7,  1'b1);
		offer(ACT_READ,   0,      4'd2,  1'b1);
		offer(ACT_READ,   0,      4'd3,  1'b1);
		offer(ACT_REMOVE, 0,      4'd1,  1'b1);

		// fill up, then full insert, duplicate into full, last slot
		for (int i = -7; i <= 6; i++)
			offer(ACT_INSERT, i, 4'($urandom), 1'b1);
		offer(ACT_INSERT, 100,    4'd0,  1'b1);
		offer(ACT_INSERT, ValMax, 4'd0,  1'b1);
		offer(ACT_READ,   0,      4'd15, 1'b1);
		offer(ACT_REMOVE, 0,      4'd15, 1'b1);
		offer(ACT_REMOVE, 0,      4'd0,  1'b1);

		// random traffic, with a stretch of back-to-back requests
		for (int i = 0; i < RandomItems; i++) begin
			offer(pick_action(i), pick_value(),
				($urandom_range(99) < 60) ? 4'($urandom_range(7)) : 4'($urandom_range(15)),
				!(i >= 250 && i < 400));
		end
		in_valid <= 1'b0;

		// drain outstanding replies, then settle
		@(posedge clk);
		while (owed != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		if (fail_count == 0)
			$display("[sorted_unique_set_table] OK");
		else
			$display("[sorted_unique_set_table] ERROR");
		$finish;
	end

endmodule

// ----- sim.f -----
design/sust_pkg.sv
design/sust_cell.sv
design/sorted_unique_set_table.sv
bench/set_table_checker.sv
bench/tb_sorted_unique_set_table.sv
